// ===== rtl/assert_macros.svh =====
// assertion helpers for the index translator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gli_pkg.sv =====
// ----------------------------------------------------------------------------
// gli_pkg
// shared constants, types and helpers of the global to local index translator
// ----------------------------------------------------------------------------
`default_nettype none

package gli_pkg;

    localparam int unsigned MaxRanges  = 256;
    localparam int unsigned MaxTargets = 64;
    localparam int unsigned MaxRemote  = 4096;

    localparam int unsigned FuncW  = 3;
    localparam int unsigned IdxW   = 13;
    localparam int unsigned GidW   = 32;
    localparam int unsigned PartW  = 8;
    localparam int unsigned LvalW  = 31;
    localparam int unsigned CfgAW  = 3;
    localparam int unsigned CfgDW  = 31;

    // item function codes
    typedef enum logic [FuncW-1:0] {
        FUNC_TRANSLATE = 3'd0,
        FUNC_WR_BOUND  = 3'd1,
        FUNC_WR_RANGE  = 3'd2,
        FUNC_WR_PART   = 3'd3,
        FUNC_WR_OFFSET = 3'd4,
        FUNC_WR_REMOTE = 3'd5
    } t_func;

    // configuration register indexes
    typedef enum logic [CfgAW-1:0] {
        CFG_OWN_RANK     = 3'd0,
        CFG_SPACE_MODE   = 3'd1,
        CFG_RANGE_COUNT  = 3'd2,
        CFG_TARGET_COUNT = 3'd3,
        CFG_LOCAL_SIZE   = 3'd4
    } t_cfg_idx;

    // index space modes
    typedef enum logic [1:0] {
        MODE_LOCAL    = 2'd0,
        MODE_REMOTE   = 2'd1,
        MODE_COMBINED = 2'd2
    } t_mode;

    localparam logic [31:0] InvalidId = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ===== rtl/gli_search_unit.sv =====
// ----------------------------------------------------------------------------
// gli_search_unit
// shared binary search step: narrows [lo, lo+len) by one compare per call
// ----------------------------------------------------------------------------
`default_nettype none

module gli_search_unit #(
    parameter int unsigned PosW = 13
) (
    input  wire logic [PosW-1:0] i_lo,
    input  wire logic [PosW-1:0] i_len,
    input  wire logic            i_go_right,
    output logic      [PosW-1:0] o_mid,
    output logic      [PosW-1:0] o_lo,
    output logic      [PosW-1:0] o_len
);

    logic [PosW-1:0] w_half;

    always_comb begin
        w_half = i_len >> 1;
        o_mid  = i_lo + w_half;
        if (i_go_right) begin
            o_lo  = o_mid + PosW'(1);
            o_len = i_len - w_half - PosW'(1);
        end else begin
            o_lo  = i_lo;
            o_len = w_half;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/global_to_local_index_translator.sv =====
// ----------------------------------------------------------------------------
// global_to_local_index_translator
// maps a global index to a local index through loaded range and remote tables
// ----------------------------------------------------------------------------
// Every item gives one result, and the block takes no item until the previous
// result has been transferred out. A table write passes through the write
// state to the done state, where its result is offered. A translate walks a
// small sequencer around one shared binary search step and one registered
// read port per table, so each compare uses the table read issued in the
// state before it; each halving takes an issue state and a compare state.
// The range search over range_count entries is followed by the range entry
// read and the start bound check. A remote lookup adds the neighbour search
// over target_count, the read of the segment bounds and the search over the
// segment. The sequencer returns to idle after the result transfer. Tables
// are undefined until written; there is no clearing pass.
`default_nettype none

module global_to_local_index_translator #(
    parameter int unsigned MAX_RANGES  = gli_pkg::MaxRanges,
    parameter int unsigned MAX_TARGETS = gli_pkg::MaxTargets,
    parameter int unsigned MAX_REMOTE  = gli_pkg::MaxRemote
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration write port
    input  wire logic                       i_cfg_we,
    input  wire logic [gli_pkg::CfgAW-1:0]  i_cfg_idx,
    input  wire logic [gli_pkg::CfgDW-1:0]  i_cfg_data,
    // item channel
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [gli_pkg::FuncW-1:0]  i_func,
    input  wire logic [gli_pkg::IdxW-1:0]   i_entry_index,
    input  wire logic [gli_pkg::GidW-1:0]   i_global_id,
    input  wire logic [gli_pkg::PartW-1:0]  i_part_value,
    input  wire logic [gli_pkg::LvalW-1:0]  i_local_value,
    // result channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [31:0]              o_local_id
);

    `include "assert_macros.svh"

    localparam int unsigned RaW = $clog2(MAX_RANGES + 2);   // range positions
    localparam int unsigned TaW = $clog2(MAX_TARGETS + 2);  // target positions
    localparam int unsigned MaW = $clog2(MAX_REMOTE + 1);   // remote positions
    localparam int unsigned RoW = $clog2(MAX_RANGES);       // range entry address
    localparam int unsigned TpW = $clog2(MAX_TARGETS);      // neighbour part address
    localparam int unsigned MiW = $clog2(MAX_REMOTE);       // remote id address
    localparam int unsigned PW  = (RaW > TaW) ? ((RaW > MaW) ? RaW : MaW)
                                              : ((TaW > MaW) ? TaW : MaW);

    // sequencer states
    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_WRITE = 12'b0000_0000_0010,
        S_RRD   = 12'b0000_0000_0100,  // range search: issue bound read
        S_RCMP  = 12'b0000_0000_1000,  // range search: compare
        S_RFIN  = 12'b0000_0001_0000,  // read range entry
        S_RCHK  = 12'b0000_0010_0000,  // check start bound, pick mode
        S_TRD   = 12'b0000_0100_0000,  // target search: issue read
        S_TCMP  = 12'b0000_1000_0000,
        S_OFS   = 12'b0001_0000_0000,  // read segment bounds
        S_MRD   = 12'b0010_0000_0000,  // remote search: issue read
        S_MCMP  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [7:0]  r_own_rank;
    logic [1:0]  r_space_mode;
    logic [8:0]  r_range_count;
    logic [6:0]  r_target_count;
    logic [30:0] r_local_size;

    // tables, one registered read port each
    logic [31:0]    m_bound  [MAX_RANGES+1];
    logic [7:0]     m_owner  [MAX_RANGES];
    logic [30:0]    m_start  [MAX_RANGES];
    logic [7:0]     m_tpart  [MAX_TARGETS];
    logic [MaW-1:0] m_toff   [MAX_TARGETS+1];
    logic [31:0]    m_remote [MAX_REMOTE];

    logic [31:0]    r_bound_q;
    logic [7:0]     r_owner_q;
    logic [30:0]    r_start_q;
    logic [7:0]     r_tpart_q;
    logic [MaW-1:0] r_toff_q;
    logic [31:0]    r_remote_q;

    // item registers
    logic [2:0]           r_func;
    logic [12:0]          r_idx;
    logic [31:0]          r_gid;
    logic [7:0]           r_part;
    logic [30:0]          r_lval;

    // search registers
    logic [PW-1:0]  r_lo, n_lo, r_len, n_len, r_hi, n_hi;
    logic [RaW-1:0] r_rid, n_rid;
    logic [7:0]     r_owner, n_owner;
    logic [31:0]    r_base, n_base;
    logic           r_phase, n_phase;   // segment bounds: end offset present
    logic [31:0]    r_res, n_res;
    logic           r_ovalid, n_ovalid;

    logic [PW-1:0] w_mid, w_slo, w_slen;
    logic          w_right;

    // read addresses
    logic [RaW-1:0] w_baddr;
    logic [RoW-1:0] w_oaddr;
    logic [TpW-1:0] w_taddr;
    logic [TaW-1:0] w_faddr;
    logic [MiW-1:0] w_maddr;

    logic [8:0]  w_rc;
    logic [6:0]  w_tc;
    logic [32:0] w_sum;
    logic [31:0] w_diff;

    gli_search_unit #(.PosW(PW)) u_search (
        .i_lo      (r_lo),
        .i_len     (r_len),
        .i_go_right(w_right),
        .o_mid     (w_mid),
        .o_lo      (w_slo),
        .o_len     (w_slen)
    );

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_local_id = r_res;

    assign w_rc = (r_range_count > 9'(MAX_RANGES)) ? 9'(MAX_RANGES) : r_range_count;
    assign w_tc = (r_target_count > 7'(MAX_TARGETS)) ? 7'(MAX_TARGETS) : r_target_count;

    // compare direction of the current search
    always_comb begin
        priority case (1'b1)
            r_state == S_RCMP: w_right = (r_bound_q <= r_gid);
            r_state == S_TCMP: w_right = (r_tpart_q < r_owner);
            default:           w_right = (r_remote_q < r_gid);
        endcase
    end

    // read address selection; segment start is read on the last target step,
    // segment end while the start is taken
    always_comb begin
        w_baddr = (r_state == S_RFIN) ? r_rid : RaW'(w_mid);
        w_oaddr = RoW'(r_rid);
        w_taddr = TpW'(w_mid);
        w_faddr = (r_state == S_OFS) ? TaW'(r_lo + PW'(1)) : TaW'(r_lo);
        w_maddr = MiW'(w_mid);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_rank     <= '0;
            r_space_mode   <= '0;
            r_range_count  <= '0;
            r_target_count <= '0;
            r_local_size   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gli_pkg::CFG_OWN_RANK:     r_own_rank     <= i_cfg_data[7:0];
                gli_pkg::CFG_SPACE_MODE:   r_space_mode   <= i_cfg_data[1:0];
                gli_pkg::CFG_RANGE_COUNT:  r_range_count  <= i_cfg_data[8:0];
                gli_pkg::CFG_TARGET_COUNT: r_target_count <= i_cfg_data[6:0];
                gli_pkg::CFG_LOCAL_SIZE:   r_local_size   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // table writes and registered reads
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            unique case (r_func)
                gli_pkg::FUNC_WR_BOUND:
                    if (r_idx <= 13'(MAX_RANGES)) m_bound[RaW'(r_idx)] <= r_gid;
                gli_pkg::FUNC_WR_RANGE:
                    if (r_idx < 13'(MAX_RANGES)) begin
                        m_owner[RoW'(r_idx)] <= r_part;
                        m_start[RoW'(r_idx)] <= r_lval;
                    end
                gli_pkg::FUNC_WR_PART:
                    if (r_idx < 13'(MAX_TARGETS)) m_tpart[TpW'(r_idx)] <= r_part;
                gli_pkg::FUNC_WR_OFFSET:
                    if (r_idx <= 13'(MAX_TARGETS))
                        m_toff[TaW'(r_idx)] <= (r_lval > 31'(MAX_REMOTE))
                            ? MaW'(MAX_REMOTE) : MaW'(r_lval);
                gli_pkg::FUNC_WR_REMOTE:
                    if (r_idx < 13'(MAX_REMOTE)) m_remote[MiW'(r_idx)] <= r_gid;
                default: ;
            endcase
        end
        r_bound_q  <= m_bound[w_baddr];
        r_owner_q  <= m_owner[w_oaddr];
        r_start_q  <= m_start[w_oaddr];
        r_tpart_q  <= m_tpart[w_taddr];
        r_toff_q   <= m_toff[w_faddr];
        r_remote_q <= m_remote[w_maddr];
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_func <= i_func;
            r_idx  <= i_entry_index;
            r_gid  <= i_global_id;
            r_part <= i_part_value;
            r_lval <= i_local_value;
        end
    end

    assign w_diff = r_gid - r_bound_q;
    assign w_sum  = {1'b0, w_diff} + {2'b0, r_start_q};

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_len    = r_len;
        n_hi     = r_hi;
        n_rid    = r_rid;
        n_owner  = r_owner;
        n_base   = r_base;
        n_phase  = r_phase;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_func == gli_pkg::FUNC_TRANSLATE) begin
                        n_state = S_RRD;
                        n_lo    = PW'(1);
                        n_len   = PW'(w_rc);
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                n_res   = gli_pkg::InvalidId;
                n_state = S_DONE;
            end
            S_RRD: begin
                if (r_len == '0) begin
                    n_rid   = RaW'(r_lo - PW'(1));
                    n_state = S_RFIN;
                end else begin
                    n_state = S_RCMP;
                end
            end
            S_RCMP: begin
                n_lo    = w_slo;
                n_len   = w_slen;
                n_state = S_RRD;
            end
            S_RFIN: begin
                n_state = S_RCHK;
            end
            S_RCHK: begin
                n_owner = r_owner_q;
                n_res   = gli_pkg::InvalidId;
                n_state = S_DONE;
                if ((r_rid < RaW'(w_rc)) && (r_gid >= r_bound_q)) begin
                    if ((r_owner_q == r_own_rank) &&
                        ((r_space_mode == gli_pkg::MODE_LOCAL) ||
                         (r_space_mode == gli_pkg::MODE_COMBINED))) begin
                        if (!w_sum[32] && !w_sum[31]) n_res = w_sum[31:0];
                    end else if ((r_space_mode == gli_pkg::MODE_REMOTE) ||
                                 (r_space_mode == gli_pkg::MODE_COMBINED)) begin
                        n_base  = (r_space_mode == gli_pkg::MODE_COMBINED)
                                ? {1'b0, r_local_size} : '0;
                        n_lo    = '0;
                        n_len   = PW'(w_tc);
                        n_state = S_TRD;
                    end
                end
            end
            S_TRD: begin
                if (r_len == '0) begin
                    if (r_lo >= PW'(w_tc)) begin
                        n_state = S_DONE;
                    end else begin
                        n_phase = 1'b0;
                        n_state = S_OFS;
                    end
                end else begin
                    n_state = S_TCMP;
                end
            end
            S_TCMP: begin
                n_lo    = w_slo;
                n_len   = w_slen;
                n_state = S_TRD;
            end
            S_OFS: begin
                if (!r_phase) begin
                    // segment start present, end read under way
                    n_phase = 1'b1;
                    n_hi    = PW'(r_toff_q);
                end else begin
                    // segment end present, start held in r_hi
                    n_phase = 1'b0;
                    if (PW'(r_toff_q) <= r_hi) begin
                        n_state = S_DONE;
                    end else begin
                        n_len   = PW'(r_toff_q) - r_hi;
                        n_lo    = r_hi;
                        n_hi    = PW'(r_toff_q);
                        n_state = S_MRD;
                    end
                end
            end
            S_MRD: begin
                n_state = S_MCMP;
            end
            S_MCMP: begin
                if (r_len == '0) begin
                    n_state = S_DONE;
                    if ((r_lo < r_hi) && (r_remote_q == r_gid)) begin
                        if ((r_space_mode == gli_pkg::MODE_COMBINED)) begin
                            if ((32'(r_lo) + r_base) <= 32'h7FFF_FFFF)
                                n_res = 32'(r_lo) + r_base;
                        end else begin
                            n_res = 32'(r_lo);
                        end
                    end
                end else begin
                    n_lo    = w_slo;
                    n_len   = w_slen;
                    n_state = S_MRD;
                end
            end
            S_DONE: begin
                n_ovalid = 1'b1;
                if (r_ovalid && !i_stall) begin
                    n_ovalid = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_phase  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_phase  <= n_phase;
        end
        r_lo    <= n_lo;
        r_len   <= n_len;
        r_hi    <= n_hi;
        r_rid   <= n_rid;
        r_owner <= n_owner;
        r_base  <= n_base;
        r_res   <= n_res;
    end

    // result valid only while the sequencer holds a finished item
    `ASSERT_IMPLY(a_valid_done, i_clk, i_rst_n, o_valid, r_state == S_DONE,
        "result valid outside done state")
    // a new item is never taken while a result is pending
    `ASSERT_IMPLY(a_no_accept_busy, i_clk, i_rst_n, o_valid, o_stall,
        "input accepted with result pending")
    // a completed result transfer returns the sequencer to idle
    `ASSERT_NEXT(a_out_idle, i_clk, i_rst_n, o_valid && !i_stall, r_state == S_IDLE,
        "sequencer not idle after result transfer")

endmodule

`default_nettype wire

// ===== bench/gli_checker.sv =====
// ----------------------------------------------------------------------------
// gli_checker
// watches both channels and the configuration port of the index translator,
// works out the expected local index of every accepted item and compares it
// with the results in order of arrival
// ----------------------------------------------------------------------------
module gli_checker
    import gli_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgAW-1:0]    i_cfg_idx,
    input  logic [CfgDW-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [FuncW-1:0]    i_func,
    input  logic [IdxW-1:0]     i_entry_index,
    input  logic [GidW-1:0]     i_global_id,
    input  logic [PartW-1:0]    i_part_value,
    input  logic [LvalW-1:0]    i_local_value,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic signed [31:0]  i_local_id,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint IdLimit = 64'h7FFF_FFFF;

    // own copy of the configuration
    logic [7:0]  rank;
    logic [1:0]  mode;
    logic [8:0]  n_ranges;
    logic [6:0]  n_targets;
    logic [30:0] owned_size;

    // own copy of the tables
    logic [31:0] bound   [0:MaxRanges];
    logic [7:0]  owner   [0:MaxRanges-1];
    logic [30:0] start   [0:MaxRanges-1];
    logic [7:0]  tpart   [0:MaxTargets-1];
    logic [12:0] toffset [0:MaxTargets];
    logic [31:0] rglobal [0:MaxRemote-1];

    logic [31:0] local_ids_due[$];
    int          fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = local_ids_due.size();

    // upper-bound search: range holding gid, or -1
    function automatic int range_of(input logic [31:0] gid);
        int unsigned rc, lo, len, half, mid;
        rc  = (n_ranges > MaxRanges) ? MaxRanges : n_ranges;
        lo  = 1;
        len = rc;
        while (len > 0) begin
            half = len / 2;
            mid  = lo + half;
            if (bound[mid] <= gid) begin
                lo  = mid + 1;
                len = len - half - 1;
            end else begin
                len = half;
            end
        end
        if (lo - 1 >= rc) return -1;
        if (gid < bound[lo-1]) return -1;
        return lo - 1;
    endfunction

    function automatic longint owned_id(input logic [31:0] gid, input int rid);
        logic [31:0] d;
        longint      v;
        if (owner[rid] != rank) return -1;
        d = gid - bound[rid];
        v = longint'(64'(d)) + longint'(64'(start[rid]));
        return (v > IdLimit) ? -1 : v;
    endfunction

    // neighbour lower-bound search, then the exact search in its segment
    function automatic longint remote_id(input logic [31:0] gid, input int rid);
        int unsigned tc, lo, hi, len, half, mid;
        tc  = (n_targets > MaxTargets) ? MaxTargets : n_targets;
        lo  = 0;
        len = tc;
        while (len > 0) begin
            half = len / 2;
            mid  = lo + half;
            if (tpart[mid] < owner[rid]) begin
                lo  = mid + 1;
                len = len - half - 1;
            end else begin
                len = half;
            end
        end
        if (lo >= tc) return -1;
        hi = toffset[lo+1];
        lo = toffset[lo];
        if (hi <= lo) return -1;
        len = hi - lo;
        while (len > 0) begin
            half = len / 2;
            mid  = lo + half;
            if (rglobal[mid] < gid) begin
                lo  = mid + 1;
                len = len - half - 1;
            end else begin
                len = half;
            end
        end
        if (lo < hi && rglobal[lo] == gid) return longint'(lo);
        return -1;
    endfunction

    function automatic logic [31:0] local_id_of(input logic [31:0] gid);
        int     rid;
        longint id;
        rid = range_of(gid);
        if (rid < 0) return InvalidId;
        case (mode)
            MODE_LOCAL:  id = owned_id(gid, rid);
            MODE_REMOTE: id = remote_id(gid, rid);
            MODE_COMBINED: begin
                if (owner[rid] == rank) begin
                    id = owned_id(gid, rid);
                end else begin
                    id = remote_id(gid, rid);
                    if (id >= 0) id = id + longint'(64'(owned_size));
                    if (id > IdLimit) id = -1;
                end
            end
            default: id = -1;
        endcase
        return (id < 0) ? InvalidId : id[31:0];
    endfunction

    always @(posedge i_clk) begin
        logic [31:0] due;
        if (!i_rst_n) begin
            rank       = '0;
            mode       = '0;
            n_ranges   = '0;
            n_targets  = '0;
            owned_size = '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_OWN_RANK:     rank       = i_cfg_data[7:0];
                    CFG_SPACE_MODE:   mode       = i_cfg_data[1:0];
                    CFG_RANGE_COUNT:  n_ranges   = i_cfg_data[8:0];
                    CFG_TARGET_COUNT: n_targets  = i_cfg_data[6:0];
                    CFG_LOCAL_SIZE:   owned_size = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            // accepted item: every item gives one result, writes give invalid
            if (i_in_valid && !i_in_stall) begin
                due = InvalidId;
                case (i_func)
                    FUNC_TRANSLATE: due = local_id_of(i_global_id);
                    FUNC_WR_BOUND:
                        if (i_entry_index <= MaxRanges) bound[i_entry_index] = i_global_id;
                    FUNC_WR_RANGE:
                        if (i_entry_index < MaxRanges) begin
                            owner[i_entry_index] = i_part_value;
                            start[i_entry_index] = i_local_value;
                        end
                    FUNC_WR_PART:
                        if (i_entry_index < MaxTargets) tpart[i_entry_index] = i_part_value;
                    FUNC_WR_OFFSET:
                        if (i_entry_index <= MaxTargets)
                            toffset[i_entry_index] = (i_local_value > MaxRemote) ?
                                13'(MaxRemote) : i_local_value[12:0];
                    FUNC_WR_REMOTE:
                        if (i_entry_index < MaxRemote) rglobal[i_entry_index] = i_global_id;
                    default: ;
                endcase
                local_ids_due.push_back(due);
            end
            if (i_out_valid && !i_out_stall) begin
                if (local_ids_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result %0d", i_local_id);
                end else begin
                    due = local_ids_due.pop_front();
                    if (i_local_id !== due) begin
                        fails++;
                        if (fails <= 10)
                            $display("local_id mismatch: expected %0d got %0d",
                                     $signed(due), i_local_id);
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_global_to_local_index_translator.sv =====
// ----------------------------------------------------------------------------
// tb_global_to_local_index_translator
// loads the range and remote tables with a consistent layout, then runs
// directed and random translate and write transfers over several register
// settings and idling patterns; a checker beside the block predicts and
// compares every result
// ----------------------------------------------------------------------------
module tb_global_to_local_index_translator;
    timeunit 1ns;
    timeprecision 1ps;
    import gli_pkg::*;

    localparam int CycleLimit    = 1000000;
    localparam int ItemsPerPhase = 100;
    localparam int NumPhases     = 8;
    // remote ids per neighbour segment, and how many are loaded
    localparam int SegLen        = 4;
    localparam int NumRemote     = SegLen * MaxTargets;
    // function codes the block must ignore
    localparam logic [FuncW-1:0] FuncSpare6 = 3'd6;
    localparam logic [FuncW-1:0] FuncSpare7 = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CfgAW-1:0]   i_cfg_idx = '0;
    logic [CfgDW-1:0]   i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [FuncW-1:0]   i_func = '0;
    logic [IdxW-1:0]    i_entry_index = '0;
    logic [GidW-1:0]    i_global_id = '0;
    logic [PartW-1:0]   i_part_value = '0;
    logic [LvalW-1:0]   i_local_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_local_id;

    int fail_count;
    int pending;
    int cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    // stimulus-side view of what was written, used only to aim translates
    logic [31:0] bnd [0:MaxRanges];
    logic [31:0] rem [0:MaxRemote-1];

    global_to_local_index_translator DUT (.*);

    gli_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_func, .i_entry_index,
        .i_global_id, .i_part_value, .i_local_value,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_local_id(o_local_id),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        while (cycles < CycleLimit) @(posedge i_clk) cycles++;
        $display("tb_global_to_local_index_translator: errors");
        $finish;
    end

    // result side: random stalls, or a long hold-off when asked for
    initial begin
        forever @(negedge i_clk) begin
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // one transfer on the item channel, called and returning at a falling edge
    task automatic send(input logic [FuncW-1:0] f, input logic [IdxW-1:0] ix,
                        input logic [31:0] g, input logic [7:0] p, input logic [30:0] lv);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= f;
        i_entry_index <= ix;
        i_global_id   <= g;
        i_part_value  <= p;
        i_local_value <= lv;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // registers are only written once the block has drained
    task automatic set_config(input logic [7:0] rank, input t_mode m, input logic [8:0] rc,
                              input logic [6:0] tc, input logic [30:0] ls);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        for (int k = 0; k < 5; k++) begin
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= k[CfgAW-1:0];
            case (t_cfg_idx'(k))
                CFG_OWN_RANK:     i_cfg_data <= 31'(rank);
                CFG_SPACE_MODE:   i_cfg_data <= 31'(m);
                CFG_RANGE_COUNT:  i_cfg_data <= 31'(rc);
                CFG_TARGET_COUNT: i_cfg_data <= 31'(tc);
                default:          i_cfg_data <= ls;
            endcase
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // segment s lists one id from each range whose index is s modulo 64
    task automatic load_tables();
        logic [31:0] w;
        int          r;
        bnd[0] = 32'($urandom_range(1, 1000));
        for (int i = 1; i <= MaxRanges; i++)
            bnd[i] = bnd[i-1] + 32'($urandom_range(16, 1 << 22));
        for (int i = 0; i <= MaxRanges; i++) send(FUNC_WR_BOUND, IdxW'(i), bnd[i], '0, '0);
        // every fourth range is local; those at 4 mod 16 start near the top
        for (int i = 0; i < MaxRanges; i++)
            send(FUNC_WR_RANGE, IdxW'(i), '0, (i % 4 == 0) ? 8'd0 : 8'(2 * (i % 64) + 1),
                 (i % 16 == 4) ? 31'h7FFF_FFF0 : 31'(i * 1000));
        for (int s = 0; s < MaxTargets; s++)
            send(FUNC_WR_PART, IdxW'(s), '0, 8'(2 * s + 1), '0);
        for (int s = 0; s <= MaxTargets; s++)
            send(FUNC_WR_OFFSET, IdxW'(s), '0, '0, 31'(SegLen * s));
        for (int j = 0; j < NumRemote; j++) begin
            r = (j / SegLen) + MaxTargets * (j % SegLen);
            w = bnd[r+1] - bnd[r];
            rem[j] = bnd[r] + ($urandom % w);
            send(FUNC_WR_REMOTE, IdxW'(j), rem[j], '0, '0);
        end
    endtask

    task automatic random_item();
        logic [FuncW-1:0] f;
        logic [IdxW-1:0]  ix;
        logic [31:0]      g, w;
        logic [7:0]       p;
        logic [30:0]      lv;
        int               sel, r;
        sel = $urandom_range(99);
        ix  = IdxW'($urandom);
        g   = $urandom;
        p   = 8'($urandom);
        lv  = 31'($urandom);
        if (sel < 60) begin
            f = FUNC_TRANSLATE;
            r = $urandom_range(9);
            if (r < 4) begin
                g = rem[$urandom_range(NumRemote - 1)];
            end else if (r < 8) begin
                r = $urandom_range(MaxRanges - 1);
                w = bnd[r+1] - bnd[r];
                g = bnd[r] + ((w == 0) ? 0 : $urandom % w);
            end
        end else if (sel < 68) begin
            f = FUNC_WR_BOUND;
            if ($urandom_range(7) != 0) ix = IdxW'($urandom_range(MaxRanges));
            if ($urandom_range(3) != 0 && ix <= MaxRanges) g = bnd[ix];
            if (ix <= MaxRanges) bnd[ix] = g;
        end else if (sel < 76) begin
            f = FUNC_WR_RANGE;
            if ($urandom_range(7) != 0) begin
                ix = IdxW'($urandom_range(MaxRanges - 1));
                p  = (ix % 4 == 0) ? 8'd0 : 8'(2 * (ix % 64) + 1);
                lv = 31'($urandom_range(100000));
            end
        end else if (sel < 82) begin
            f = FUNC_WR_PART;
            if ($urandom_range(7) != 0) begin
                ix = IdxW'($urandom_range(MaxTargets - 1));
                p  = 8'(2 * ix + 1);
            end
        end else if (sel < 88) begin
            f = FUNC_WR_OFFSET;
            if ($urandom_range(7) != 0) ix = IdxW'($urandom_range(MaxTargets));
            // segments only ever cover loaded remote ids
            if (ix <= MaxTargets) lv = 31'(SegLen * ix);
        end else if (sel < 96) begin
            f = FUNC_WR_REMOTE;
            if ($urandom_range(7) != 0) ix = IdxW'($urandom_range(NumRemote - 1));
            if ($urandom_range(3) != 0 && ix < NumRemote) g = rem[ix];
            if (ix < MaxRemote) rem[ix] = g;
        end else begin
            f = ($urandom_range(1) != 0) ? FuncSpare6 : FuncSpare7;
        end
        send(f, ix, g, p, lv);
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_config(8'd0, MODE_LOCAL, 9'd256, 7'd64, 31'd0);
        load_tables();

        // directed: edges of the range table, ignored writes, spare codes
        send(FUNC_TRANSLATE, '0, bnd[0], '0, '0);
        send(FUNC_TRANSLATE, '0, bnd[0] - 1, '0, '0);
        send(FUNC_TRANSLATE, '0, 32'd0, '0, '0);
        send(FUNC_TRANSLATE, '1, 32'hFFFF_FFFF, '1, '1);
        send(FUNC_TRANSLATE, '0, bnd[MaxRanges] - 1, '0, '0);
        send(FUNC_TRANSLATE, '0, bnd[MaxRanges], '0, '0);
        send(FUNC_TRANSLATE, '0, bnd[8] + 5, '0, '0);
        send(FUNC_TRANSLATE, '0, bnd[5] + 5, '0, '0);
        // local start near the top: offset past 15 overflows
        send(FUNC_TRANSLATE, '0, bnd[4] + 15, '0, '0);
        send(FUNC_TRANSLATE, '0, bnd[5] - 1, '0, '0);
        send(FUNC_TRANSLATE, '0, rem[100], '0, '0);
        send(FuncSpare6, '1, '1, '1, '1);
        send(FuncSpare7, '0, '0, '0, '0);
        send(FUNC_WR_BOUND, 13'd257, '1, '0, '0);
        send(FUNC_WR_BOUND, '1, '1, '1, '1);
        send(FUNC_WR_RANGE, 13'd256, '0, '1, '1);
        send(FUNC_WR_PART, 13'd64, '0, '1, '0);
        send(FUNC_WR_OFFSET, 13'd65, '0, '0, '0);
        // saturating offset write, then the loaded end offset again
        send(FUNC_WR_OFFSET, 13'd64, '0, '0, 31'h7FFF_FFFF);
        send(FUNC_WR_OFFSET, 13'd64, '0, '0, 31'(NumRemote));
        send(FUNC_WR_REMOTE, 13'd4096, '0, '0, '0);
        send(FUNC_TRANSLATE, '0, rem[200], '0, '0);

        for (int ph = 0; ph < NumPhases; ph++) begin
            case (ph)
                0: set_config(8'd0,   MODE_LOCAL,    9'd256, 7'd64,  31'd0);
                1: set_config(8'd0,   MODE_REMOTE,   9'd256, 7'd64,  31'd12345);
                2: set_config(8'd0,   MODE_COMBINED, 9'd256, 7'd64,  31'h7FFF_FFFF);
                3: set_config(8'd255, MODE_COMBINED, 9'd511, 7'd127, 31'd1000);
                4: set_config(8'd0,   t_mode'(2'd3), 9'd100, 7'd30,  31'd5);
                5: set_config(8'd4,   MODE_COMBINED, 9'd0,   7'd0,   31'd77);
                6: set_config(8'd0,   MODE_REMOTE,   9'd1,   7'd1,   31'd0);
                default: set_config(8'd0, MODE_COMBINED, 9'd256, 7'd64, 31'h4000_0000);
            endcase
            idle_pct  = (ph % 4 == 1) ? 48 : (ph % 4 == 3) ? 21 : 0;
            stall_pct = (ph % 4 == 2) ? 48 : (ph % 4 == 3) ? 21 : 0;
            // long hold-off on the result side while items keep coming
            if (ph == 1) begin
                @(posedge i_clk);
                hold_left = 400;
                @(negedge i_clk);
            end
            for (int n = 0; n < ItemsPerPhase; n++) random_item();
        end

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_global_to_local_index_translator: clean");
        end else begin
            $display("tb_global_to_local_index_translator: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gli_pkg.sv
rtl/gli_search_unit.sv
rtl/global_to_local_index_translator.sv
bench/gli_checker.sv
bench/tb_global_to_local_index_translator.sv
